>>> src/matrix3x3_inverse_top_macros.svh
// Assertion macros used by the checker of matrix3x3_inverse_top.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef MATRIX3X3_INVERSE_TOP_MACROS_SVH
`define MATRIX3X3_INVERSE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define MI3_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 assertion failed");

// Next-cycle implication, active through reset as well
`define MI3_ASSERT_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mi3 assertion failed");

`endif

>>> src/mi3_pkg.sv
// Package for the 3x3 matrix inverse: payload structs, widths, index tables.
// No dependencies; used by every module of the block but mi3_fifo.
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int COF_W  = 66;   // signed cofactor, |c| < 2^63
  localparam int DET_W  = 98;   // signed determinant, |d| < 2^96
  localparam int NUM_W  = 96;   // |cofactor| << 32
  localparam int QUO_W  = 33;   // quotient bits developed by the divider
  localparam int REM_W  = 130;  // holds divisor << (QUO_W)

  typedef logic [3:0] idx_t;

  typedef struct packed {
    logic signed [31:0] in_r0c0;
    logic signed [31:0] in_r0c1;
    logic signed [31:0] in_r0c2;
    logic signed [31:0] in_r1c0;
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r2c0;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_r0c0;
    logic signed [31:0] out_r0c1;
    logic signed [31:0] out_r0c2;
    logic signed [31:0] out_r1c0;
    logic signed [31:0] out_r1c1;
    logic signed [31:0] out_r1c2;
    logic signed [31:0] out_r2c0;
    logic signed [31:0] out_r2c1;
    logic signed [31:0] out_r2c2;
    logic signed [31:0] det_value;
    logic               singular;
    logic               saturated;
  } out_item_t;

  // Front-to-back request: exact cofactors (adjugate order) and determinant
  typedef struct packed {
    logic [8:0][COF_W-1:0] cof;
    logic [DET_W-1:0]      det;
    logic                  zero;
  } mid_item_t;

  // Sarrus terms: det = t0 + t1 + t2 - t3 - t4 - t5
  localparam idx_t DET_IDX [6][3] = '{
    '{4'd0, 4'd4, 4'd8}, '{4'd1, 4'd5, 4'd6}, '{4'd2, 4'd3, 4'd7},
    '{4'd2, 4'd4, 4'd6}, '{4'd5, 4'd7, 4'd0}, '{4'd8, 4'd3, 4'd1}
  };

  // Adjugate entry k = e[a]*e[b] - e[c]*e[d]
  localparam idx_t ADJ_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Row-major element vector, index 0 = r0c0
  function automatic logic [8:0][31:0] elems(in_item_t x);
    return {x.in_r2c2, x.in_r2c1, x.in_r2c0, x.in_r1c2, x.in_r1c1, x.in_r1c0,
            x.in_r0c2, x.in_r0c1, x.in_r0c0};
  endfunction

endpackage

>>> src/mi3_fifo.sv
// Small synchronous queue with flag outputs, used between and after stages.
// No package dependency; storage is a register array read at the head.
module mi3_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/mi3_front.sv
// Front end: accepts matrices, forms exact determinant and cofactors.
// Depends on mi3_pkg; five pipeline stages feeding the middle queue.
module mi3_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mi3_pkg::in_item_t   item,
  output logic                mid_push,
  input  logic                mid_full,
  output mi3_pkg::mid_item_t  mid_item
);

  logic [8:0][31:0] e;
  logic [4:0]       vld;
  logic             en;

  // stage 1: 32x32 products
  logic signed [63:0] ab [6];
  logic signed [31:0] c1 [6];
  logic signed [63:0] pa [9];
  logic signed [63:0] pb [9];
  // stage 2: partial products of the triple terms, cofactor differences
  logic signed [63:0] dhi [6];
  logic signed [64:0] dlo [6];
  logic signed [mi3_pkg::COF_W-1:0] cof2 [9];
  // stage 3: full triple terms
  logic signed [mi3_pkg::DET_W-1:0] term [6];
  logic signed [mi3_pkg::COF_W-1:0] cof3 [9];
  // stage 4: add/subtract pairs
  logic signed [mi3_pkg::DET_W-1:0] pair [3];
  logic signed [mi3_pkg::COF_W-1:0] cof4 [9];
  // stage 5: determinant
  logic signed [mi3_pkg::DET_W-1:0] det5;
  logic signed [mi3_pkg::COF_W-1:0] cof5 [9];

  assign e        = mi3_pkg::elems(item);
  assign en       = !(vld[4] && mid_full);
  assign full     = !en;
  assign mid_push = vld[4] && !mid_full;

  // valid chain; the whole pipe holds while its last request waits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], push};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        ab[k]   <= $signed(e[mi3_pkg::DET_IDX[k][0]]) * $signed(e[mi3_pkg::DET_IDX[k][1]]);
        c1[k]   <= $signed(e[mi3_pkg::DET_IDX[k][2]]);
        dhi[k]  <= $signed(ab[k][63:32]) * c1[k];
        dlo[k]  <= $signed({1'b0, ab[k][31:0]}) * c1[k];
        term[k] <= (mi3_pkg::DET_W'(dhi[k]) <<< 32) + mi3_pkg::DET_W'(dlo[k]);
      end
      for (int k = 0; k < 9; k++) begin
        pa[k]   <= $signed(e[mi3_pkg::ADJ_IDX[k][0]]) * $signed(e[mi3_pkg::ADJ_IDX[k][1]]);
        pb[k]   <= $signed(e[mi3_pkg::ADJ_IDX[k][2]]) * $signed(e[mi3_pkg::ADJ_IDX[k][3]]);
        cof2[k] <= mi3_pkg::COF_W'(pa[k]) - mi3_pkg::COF_W'(pb[k]);
        cof3[k] <= cof2[k];
        cof4[k] <= cof3[k];
        cof5[k] <= cof4[k];
      end
      for (int j = 0; j < 3; j++) begin
        pair[j] <= term[j] - term[j+3];
      end
      det5 <= pair[0] + pair[1] + pair[2];
    end
  end

  // request to the back end
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mid_item.cof[k] = cof5[k];
    end
    mid_item.det  = det5;
    mid_item.zero = (det5 == '0);
  end

endmodule

>>> src/mi3_back.sv
// Back end: nine restoring divider lanes, saturation and the result queue.
// Depends on mi3_pkg and mi3_fifo; one quotient bit per stage.
module mi3_back #(
  parameter int OUT_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_empty,
  output logic                mid_pop,
  input  mi3_pkg::mid_item_t  mid_item,
  output logic                empty,
  input  logic                pop,
  output mi3_pkg::out_item_t  result
);

  localparam int NST  = mi3_pkg::QUO_W;
  localparam int DM_W = mi3_pkg::DET_W - 1;

  logic [NST:0] vld;
  logic         en, out_full, out_push;

  logic [mi3_pkg::REM_W-1:0] rem [NST+1][9];
  logic [mi3_pkg::QUO_W-1:0] quo [NST+1][9];
  logic [DM_W-1:0]           dm  [NST+1];
  logic [8:0]                neg [NST+1];
  logic [8:0]                ovf [NST+1];
  logic                      sing [NST+1];
  logic [31:0]               detv [NST+1];
  logic                      dsat [NST+1];

  // entry stage combinational terms
  logic signed [mi3_pkg::DET_W-1:0] det_s;
  logic [mi3_pkg::DET_W-1:0]        dmag;
  logic                             dneg;
  logic [65:0]                      dtop;
  logic [31:0]                      dval;
  logic                             dsat0;
  logic [mi3_pkg::COF_W-1:0]        cmag [9];
  logic [8:0]                       cneg;
  logic [mi3_pkg::NUM_W-1:0]        num [9];
  logic [8:0]                       ovf0;

  mi3_pkg::out_item_t out_d;
  logic [8:0][31:0]   vals;
  logic               any_sat;

  assign en       = !(vld[NST] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = vld[NST] && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:0], !mid_empty};
    end
  end

  // magnitudes, signs, overflow precheck and determinant output
  always_comb begin
    det_s = $signed(mid_item.det);
    dneg  = mid_item.det[mi3_pkg::DET_W-1];
    dmag  = dneg ? mi3_pkg::DET_W'(-det_s) : mid_item.det;
    dtop  = dmag[mi3_pkg::DET_W-1:32];
    if (dneg) begin
      dsat0 = (dtop > 66'h0_8000_0000);
      dval  = dsat0 ? 32'h8000_0000 : 32'(-dtop[31:0]);
    end else begin
      dsat0 = (dtop > 66'h0_7FFF_FFFF);
      dval  = dsat0 ? 32'h7FFF_FFFF : dtop[31:0];
    end
    for (int k = 0; k < 9; k++) begin
      cneg[k] = mid_item.cof[k][mi3_pkg::COF_W-1];
      cmag[k] = cneg[k] ? mi3_pkg::COF_W'(-$signed(mid_item.cof[k])) : mid_item.cof[k];
      num[k]  = {cmag[k][63:0], 32'b0};
      ovf0[k] = (mi3_pkg::REM_W'(num[k]) >=
                 (mi3_pkg::REM_W'(dmag[DM_W-1:0]) << mi3_pkg::QUO_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        rem[0][k] <= mi3_pkg::REM_W'(num[k]);
        quo[0][k] <= '0;
      end
      dm[0]   <= dmag[DM_W-1:0];
      neg[0]  <= cneg ^ {9{dneg}};
      ovf[0]  <= ovf0;
      sing[0] <= mid_item.zero;
      detv[0] <= dval;
      dsat[0] <= dsat0;
    end
  end

  // divider stages, most significant quotient bit first
  for (genvar s = 1; s <= NST; s++) begin : g_div
    localparam int BIT = NST - s;
    logic [mi3_pkg::REM_W-1:0] shd;
    logic [8:0]                ge;
    logic [mi3_pkg::REM_W-1:0] diff [9];

    always_comb begin
      shd = mi3_pkg::REM_W'(dm[s-1]) << BIT;
      for (int k = 0; k < 9; k++) begin
        diff[k] = rem[s-1][k] - shd;
        ge[k]   = (rem[s-1][k] >= shd);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 9; k++) begin
          rem[s][k] <= ge[k] ? diff[k] : rem[s-1][k];
          quo[s][k] <= quo[s-1][k] | (mi3_pkg::QUO_W'(ge[k]) << BIT);
        end
        dm[s]   <= dm[s-1];
        neg[s]  <= neg[s-1];
        ovf[s]  <= ovf[s-1];
        sing[s] <= sing[s-1];
        detv[s] <= detv[s-1];
        dsat[s] <= dsat[s-1];
      end
    end
  end

  // sign, saturation and the singular case
  always_comb begin
    logic sat_k;
    any_sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (neg[NST][k]) begin
        sat_k   = ovf[NST][k] || (quo[NST][k] > 33'h0_8000_0000);
        vals[k] = sat_k ? 32'h8000_0000 : 32'(-quo[NST][k][31:0]);
      end else begin
        sat_k   = ovf[NST][k] || (quo[NST][k] > 33'h0_7FFF_FFFF);
        vals[k] = sat_k ? 32'h7FFF_FFFF : quo[NST][k][31:0];
      end
      any_sat = any_sat | sat_k;
    end
    if (sing[NST]) begin
      vals    = '0;
      any_sat = 1'b0;
    end
    out_d.out_r0c0  = vals[0];
    out_d.out_r0c1  = vals[1];
    out_d.out_r0c2  = vals[2];
    out_d.out_r1c0  = vals[3];
    out_d.out_r1c1  = vals[4];
    out_d.out_r1c2  = vals[5];
    out_d.out_r2c0  = vals[6];
    out_d.out_r2c1  = vals[7];
    out_d.out_r2c2  = vals[8];
    out_d.det_value = sing[NST] ? 32'h0 : detv[NST];
    out_d.singular  = sing[NST];
    out_d.saturated = sing[NST] ? 1'b0 : (any_sat | dsat[NST]);
  end

  // result queue
  mi3_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(mi3_pkg::out_item_t))
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (out_d),
    .full  (out_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

>>> src/matrix3x3_inverse_top.sv
// 3x3 matrix inverse, signed Q16.16, by determinant and adjugate. Sustains one
// matrix per clock with no bubbles while the result side keeps up. When nothing
// stalls, a result passes through four front stages after the capture register
// for the exact products and sums, the middle queue, one sign/precheck stage,
// 33 stages of nine parallel restoring divider lanes (one quotient bit each), which
// set the latency, and one result-queue write. Results appear in input order; a
// stalled result side fills the queues and then raises full. No clearing pass
// after reset. Depends on mi3_pkg, mi3_front, mi3_fifo, mi3_back.
module matrix3x3_inverse_top #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mi3_pkg::in_item_t   item,
  output logic                empty,
  input  logic                pop,
  output mi3_pkg::out_item_t  result
);

  logic               mid_push, mid_full, mid_pop, mid_empty;
  mi3_pkg::mid_item_t mid_in, mid_out;

  // determinant and cofactors
  mi3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_item (mid_in)
  );

  // decoupling queue between front and back
  mi3_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH ($bits(mi3_pkg::mid_item_t))
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .rd    (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // division, saturation, result queue
  mi3_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_out),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

>>> src/mi3_checker.sv
// Port-level checker for matrix3x3_inverse_top, bound to the top level.
// Depends on mi3_pkg and matrix3x3_inverse_top_macros.svh.
`include "matrix3x3_inverse_top_macros.svh"

module mi3_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mi3_pkg::out_item_t result
);

  // reset leaves no results and room for a request
  `MI3_ASSERT_NEXT(a_reset_idle, clk, rst, empty && !full)

  // a singular result has a zero diagonal, a zero det_value and no saturated flag
  `MI3_ASSERT_IMP(a_singular_zero, clk, rst, !empty && result.singular, result.out_r0c0 == 0 && result.out_r1c1 == 0 && result.out_r2c2 == 0 && result.det_value == 0 && !result.saturated)

  // a waiting result stays put until taken
  `MI3_ASSERT_IMP(a_hold, clk, rst, !empty && !pop, ##1 (rst || (!empty && $stable(result))))

endmodule

bind matrix3x3_inverse_top mi3_checker u_mi3_checker (.*);
